// ===== rtl/fjpm_pkg.sv =====
// Shared types and constants of the flash journal pointer manager.
// Used by the interfaces, controller, datapath, top level and checker.
package fjpm_pkg;

  localparam int MAX_BLOCKS  = 4096;
  localparam int MAX_RETRIES = 8;
  localparam int PAGE_W      = 24;
  localparam int BLK_W       = $clog2(MAX_BLOCKS);
  localparam int CNT_W       = BLK_W + 1;
  localparam int RETRY_W     = (MAX_RETRIES > 1) ? $clog2(MAX_RETRIES) : 1;
  localparam int BAD_SHIFT   = 6;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CNT_W-1:0]   BLK_CNT_RST  = CNT_W'(MAX_BLOCKS);
  localparam logic [3:0]         LPPB_RST     = 4'd6;
  localparam logic [3:0]         LGP_RST      = 4'd2;
  localparam logic [CNT_W-1:0]   BAD_LAST_RST = CNT_W'(MAX_BLOCKS >> BAD_SHIFT);
  localparam logic [RETRY_W-1:0] RETRY_LAST   = RETRY_W'(MAX_RETRIES - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_COUNT = 2'd0,
    CFG_LOG2_PPB    = 2'd1,
    CFG_LOG2_GROUP  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ACT_RESET   = 3'd0,
    ACT_MARK    = 3'd1,
    ACT_ENQUEUE = 3'd2,
    ACT_DEQUEUE = 3'd3,
    ACT_CLEAR   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_FULL = 2'd1,
    STS_BAD  = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_EXEC,
    S_MET1, S_MET2, S_MET3, S_MET4, S_MET5,
    S_ENQ_CHK, S_ENQ_PROG, S_HS_A, S_HS_B, S_TS_A, S_TS_B, S_FIN
  } state_t;

  typedef enum logic [4:0] {
    DP_NONE, DP_CLR, DP_LOAD, DP_INIT, DP_MARK, DP_CLEARJ,
    DP_MET1, DP_MET2, DP_MET3, DP_MET4, DP_MET5,
    DP_ENQ_FULL, DP_ENQ_PROG, DP_HS_A, DP_HS_B,
    DP_DEQ, DP_TS_A, DP_TS_B, DP_OUT
  } dp_op_t;

  typedef struct packed {
    logic       clr_done;
    logic [2:0] action;
    logic       full;
    logic       enq_scan;
    logic       deq_scan;
    logic       at_tail;
    logic       at_head;
    logic       rd_bad;
    logic       cnt_last;
  } dp_stat_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] head_page;
    logic [PAGE_W-1:0] tail_page;
    logic [PAGE_W-1:0] root_page;
    logic              root_valid;
    logic              erase_request;
    logic [BLK_W-1:0]  erase_block_number;
    logic              checkpoint_request;
    logic [PAGE_W-1:0] checkpoint_page;
    logic [PAGE_W-1:0] journal_size;
    logic [PAGE_W-1:0] journal_capacity;
    logic [7:0]        epoch_count;
  } out_item_t;

endpackage

// ===== rtl/fjpm_in_if.sv =====
// Action channel of the journal pointer manager.
// Depends on fjpm_pkg for field widths.
interface fjpm_in_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                action;
  logic [fjpm_pkg::BLK_W-1:0] block_number;

  modport source (output valid, action, block_number, input ready);
  modport sink   (input valid, action, block_number, output ready);
endinterface

// ===== rtl/fjpm_out_if.sv =====
// Result channel of the journal pointer manager.
// Depends on fjpm_pkg for field widths.
interface fjpm_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [fjpm_pkg::PAGE_W-1:0] head_page;
  logic [fjpm_pkg::PAGE_W-1:0] tail_page;
  logic [fjpm_pkg::PAGE_W-1:0] root_page;
  logic                        root_valid;
  logic                        erase_request;
  logic [fjpm_pkg::BLK_W-1:0]  erase_block_number;
  logic                        checkpoint_request;
  logic [fjpm_pkg::PAGE_W-1:0] checkpoint_page;
  logic [fjpm_pkg::PAGE_W-1:0] journal_size;
  logic [fjpm_pkg::PAGE_W-1:0] journal_capacity;
  logic [7:0]                  epoch_count;

  modport source (output valid, status, head_page, tail_page, root_page, root_valid,
                  erase_request, erase_block_number, checkpoint_request,
                  checkpoint_page, journal_size, journal_capacity, epoch_count,
                  input ready);
  modport sink   (input valid, status, head_page, tail_page, root_page, root_valid,
                  erase_request, erase_block_number, checkpoint_request,
                  checkpoint_page, journal_size, journal_capacity, epoch_count,
                  output ready);
endinterface

// ===== rtl/fjpm_datapath.sv =====
// Datapath: configuration, journal pointers, bad-block map memory, scan and metrics.
// Driven by fjpm_ctrl through dp_op_t commands; depends on fjpm_pkg.
module fjpm_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fjpm_pkg::dp_op_t                    op,
  input  logic                                cfg_we,
  input  logic [fjpm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fjpm_pkg::CFG_W-1:0]          cfg_data,
  input  logic [2:0]                          in_action,
  input  logic [fjpm_pkg::BLK_W-1:0]          in_block_number,
  output fjpm_pkg::dp_stat_t                  stat,
  output fjpm_pkg::out_item_t                 out_item
);

  localparam int PW = fjpm_pkg::PAGE_W;
  localparam int BW = fjpm_pkg::BLK_W;
  localparam int CW = fjpm_pkg::CNT_W;
  localparam int RW = fjpm_pkg::RETRY_W;

  // configuration
  logic [CW-1:0] blk_cnt_r;
  logic [3:0]    lppb_r, lgp_r;
  logic [CW-1:0] nb;
  logic [3:0]    pb, pc;

  // journal state
  logic [PW-1:0] head_r, head_nxt, tail_r, tail_nxt, root_r, root_nxt;
  logic          root_def_r, root_def_nxt;
  logic [7:0]    epoch_r, epoch_nxt;
  logic [CW-1:0] bad_this_r, bad_this_nxt, bad_last_r, bad_last_nxt;
  logic [BW-1:0] clr_addr_r, clr_addr_nxt;

  // per-transaction work registers
  logic [2:0]    act_r, act_nxt;
  logic [BW-1:0] bnum_r, bnum_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          erq_r, erq_nxt, cprq_r, cprq_nxt;
  logic [BW-1:0] eblk_r, eblk_nxt;
  logic [PW-1:0] cpage_r, cpage_nxt, old_r, old_nxt, blk_r, blk_nxt;
  logic [CW-1:0] cur_r, cur_nxt, last_r, last_nxt;
  logic [7:0]    e_r, e_nxt;
  logic [RW-1:0] cnt_r, cnt_nxt;

  // metrics pipeline
  logic [PW:0]   total_r, total_nxt, addc_r, addc_nxt, hc_r, hc_nxt, cps_r, cps_nxt;
  logic [CW-1:0] mb_r, mb_nxt;
  logic          hlt_r, hlt_nxt, gz_r, gz_nxt, pneg_r, pneg_nxt, cneg_r, cneg_nxt;
  logic [PW+1:0] hp_r, hp_nxt, pages_r, pages_nxt;
  logic [BW-1:0] good_r, good_nxt;
  logic [PW-1:0] cpsc_r, cpsc_nxt, size_r, size_nxt, cap_r, cap_nxt;
  fjpm_pkg::out_item_t out_item_r, out_item_nxt;

  // bad-block map
  logic          bad_mem [fjpm_pkg::MAX_BLOCKS];
  logic          rd_bad_r;
  logic          mem_we, mem_wdata;
  logic [BW-1:0] mem_waddr, mem_raddr;

  logic [PW-1:0] pb_mask, pc_mask, head_bnum, tail_blk;
  logic [PW-1:0] h1, h2, t1, t2, tsel, hs_inc, nblk;
  logic          head_aligned, ccp, hs_wrap, blk_eq_tail, blk_eq_head;
  logic [PW:0]   add, tc;

  assign nb = (blk_cnt_r < CW'(2)) ? CW'(2) :
              (blk_cnt_r > CW'(fjpm_pkg::MAX_BLOCKS)) ? CW'(fjpm_pkg::MAX_BLOCKS) :
              blk_cnt_r;
  assign pb = (lppb_r < 4'd1) ? 4'd1 : (lppb_r > 4'd12) ? 4'd12 : lppb_r;
  assign pc = (lgp_r < 4'd1) ? 4'd1 : (lgp_r > pb) ? pb : lgp_r;

  assign pb_mask   = (PW'(1) << pb) - PW'(1);
  assign pc_mask   = (PW'(1) << pc) - PW'(1);
  assign head_bnum = head_r >> pb;
  assign tail_blk  = tail_r >> pb;
  assign head_aligned = (head_r & pb_mask) == '0;

  assign h1   = head_r + PW'(1);
  assign h2   = head_r + PW'(2);
  assign ccp  = (h2 & pc_mask) == '0;
  assign t1   = tail_r + PW'(1);
  assign t2   = tail_r + PW'(2);
  assign tsel = ((t2 & pc_mask) == '0) ? t2 : t1;

  // next block of a scan, wrapping at the end of the array
  assign hs_inc  = blk_r + PW'(1);
  assign hs_wrap = hs_inc >= PW'(nb);
  assign nblk    = hs_wrap ? '0 : hs_inc;
  assign blk_eq_tail = blk_r == tail_blk;
  assign blk_eq_head = blk_r == head_bnum;

  assign add = hlt_r ? total_r : '0;
  assign tc  = {1'b0, tail_r >> pc};

  always_comb begin
    stat.clr_done  = clr_addr_r == '1;
    stat.action    = act_r;
    stat.full      = (size_r >= cap_r) ||
                     (head_aligned && (head_r < tail_r) && (head_bnum == tail_blk));
    stat.enq_scan  = ccp && ((h2 & pb_mask) == '0);
    stat.deq_scan  = (tail_r != head_r) && ((tsel & pb_mask) == '0);
    stat.at_tail   = blk_eq_tail;
    stat.at_head   = blk_eq_head;
    stat.rd_bad    = rd_bad_r;
    stat.cnt_last  = cnt_r == fjpm_pkg::RETRY_LAST;
  end

  always_comb begin
    head_nxt = head_r;  tail_nxt = tail_r;  root_nxt = root_r;
    root_def_nxt = root_def_r;  epoch_nxt = epoch_r;
    bad_this_nxt = bad_this_r;  bad_last_nxt = bad_last_r;
    clr_addr_nxt = clr_addr_r;
    act_nxt = act_r;  bnum_nxt = bnum_r;  status_nxt = status_r;
    erq_nxt = erq_r;  eblk_nxt = eblk_r;  cprq_nxt = cprq_r;  cpage_nxt = cpage_r;
    old_nxt = old_r;  blk_nxt = blk_r;  cur_nxt = cur_r;  last_nxt = last_r;
    e_nxt = e_r;  cnt_nxt = cnt_r;
    total_nxt = total_r;  mb_nxt = mb_r;  hlt_nxt = hlt_r;  hp_nxt = hp_r;
    addc_nxt = addc_r;  gz_nxt = gz_r;  good_nxt = good_r;  hc_nxt = hc_r;
    pneg_nxt = pneg_r;  pages_nxt = pages_r;  cpsc_nxt = cpsc_r;
    cneg_nxt = cneg_r;  cps_nxt = cps_r;  size_nxt = size_r;  cap_nxt = cap_r;
    out_item_nxt = out_item_r;
    mem_we = 1'b0;  mem_wdata = 1'b0;  mem_waddr = bnum_r;  mem_raddr = nblk[BW-1:0];

    unique case (op)
      fjpm_pkg::DP_CLR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + BW'(1);
      end
      fjpm_pkg::DP_LOAD: begin
        act_nxt    = in_action;
        bnum_nxt   = in_block_number;
        status_nxt = fjpm_pkg::STS_OK;
        erq_nxt    = 1'b0;
        eblk_nxt   = '0;
        cprq_nxt   = 1'b0;
        cpage_nxt  = '0;
      end
      fjpm_pkg::DP_INIT: begin
        head_nxt     = '0;
        tail_nxt     = '0;
        root_nxt     = '0;
        root_def_nxt = 1'b0;
        epoch_nxt    = '0;
        bad_this_nxt = '0;
        bad_last_nxt = nb >> fjpm_pkg::BAD_SHIFT;
      end
      fjpm_pkg::DP_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = 1'b1;
      end
      fjpm_pkg::DP_CLEARJ: begin
        tail_nxt     = head_r;
        root_def_nxt = 1'b0;
      end
      fjpm_pkg::DP_MET1: begin
        total_nxt = {{(PW+1-CW){1'b0}}, nb} << pb;
        mb_nxt    = (bad_last_r > bad_this_r) ? bad_last_r : bad_this_r;
        hlt_nxt   = head_r < tail_r;
      end
      fjpm_pkg::DP_MET2: begin
        hp_nxt   = {2'b0, head_r} + {1'b0, add};
        addc_nxt = add >> pc;
        gz_nxt   = ({1'b0, mb_r} + (CW+1)'(1)) >= {1'b0, nb};
        good_nxt = BW'(nb - mb_r - CW'(1));
      end
      fjpm_pkg::DP_MET3: begin
        hc_nxt    = {1'b0, head_r >> pc} + addc_r;
        pneg_nxt  = hp_r < {2'b0, tail_r};
        pages_nxt = hp_r - {2'b0, tail_r};
        cpsc_nxt  = {{(PW-BW){1'b0}}, good_r} << (pb - pc);
      end
      fjpm_pkg::DP_MET4: begin
        cneg_nxt = hc_r < tc;
        cps_nxt  = hc_r - tc;
        cap_nxt  = gz_r ? '0 : PW'(({1'b0, cpsc_r} << pc) - {1'b0, cpsc_r});
      end
      fjpm_pkg::DP_MET5: begin
        if (pneg_r || cneg_r || (pages_r < {1'b0, cps_r})) begin
          size_nxt = '0;
        end else begin
          size_nxt = PW'(pages_r - {1'b0, cps_r});
        end
      end
      fjpm_pkg::DP_ENQ_FULL: status_nxt = fjpm_pkg::STS_FULL;
      fjpm_pkg::DP_ENQ_PROG: begin
        old_nxt = head_r;
        if (head_aligned) begin
          erq_nxt  = 1'b1;
          eblk_nxt = head_bnum[BW-1:0];
        end
        if (!ccp) begin
          head_nxt     = h1;
          root_nxt     = head_r;
          root_def_nxt = 1'b1;
        end else begin
          cprq_nxt  = 1'b1;
          cpage_nxt = h1;
          if ((h2 & pb_mask) == '0) begin
            // block used up: set up the head scan
            head_nxt = h1;
            blk_nxt  = h1 >> pb;
            cur_nxt  = bad_this_r;
            last_nxt = bad_last_r;
            e_nxt    = epoch_r;
            cnt_nxt  = '0;
          end else begin
            head_nxt     = h2;
            root_nxt     = head_r;
            root_def_nxt = 1'b1;
          end
        end
      end
      fjpm_pkg::DP_HS_A: begin
        blk_nxt = nblk;
        if (hs_wrap) begin
          e_nxt    = e_r + 8'd1;
          last_nxt = cur_r;
          cur_nxt  = '0;
        end
      end
      fjpm_pkg::DP_HS_B: begin
        if (blk_eq_tail) begin
          head_nxt   = old_r;
          status_nxt = fjpm_pkg::STS_BAD;
        end else if (!rd_bad_r) begin
          head_nxt     = PW'(blk_r << pb);
          bad_last_nxt = last_r;
          bad_this_nxt = cur_r;
          epoch_nxt    = e_r;
          root_nxt     = old_r;
          root_def_nxt = 1'b1;
        end else begin
          cur_nxt = cur_r + CW'(1);
          cnt_nxt = cnt_r + RW'(1);
          if (cnt_r == fjpm_pkg::RETRY_LAST) begin
            head_nxt   = old_r;
            status_nxt = fjpm_pkg::STS_BAD;
          end
        end
      end
      fjpm_pkg::DP_DEQ: begin
        if (tail_r != head_r) begin
          if ((tsel & pb_mask) == '0) begin
            blk_nxt = tail_blk;
            cnt_nxt = '0;
          end else begin
            tail_nxt = tsel;
          end
        end
      end
      fjpm_pkg::DP_TS_A: begin
        if (blk_eq_head) begin
          status_nxt = fjpm_pkg::STS_BAD;
        end else begin
          blk_nxt = nblk;
        end
      end
      fjpm_pkg::DP_TS_B: begin
        if (!rd_bad_r) begin
          tail_nxt = PW'(blk_r << pb);
        end else begin
          cnt_nxt = cnt_r + RW'(1);
          if (cnt_r == fjpm_pkg::RETRY_LAST) status_nxt = fjpm_pkg::STS_BAD;
        end
      end
      fjpm_pkg::DP_OUT: begin
        out_item_nxt.status             = status_r;
        out_item_nxt.head_page          = head_r;
        out_item_nxt.tail_page          = tail_r;
        out_item_nxt.root_page          = root_def_r ? root_r : '0;
        out_item_nxt.root_valid         = root_def_r;
        out_item_nxt.erase_request      = erq_r;
        out_item_nxt.erase_block_number = eblk_r;
        out_item_nxt.checkpoint_request = cprq_r;
        out_item_nxt.checkpoint_page    = cpage_r;
        out_item_nxt.journal_size       = size_r;
        out_item_nxt.journal_capacity   = cap_r;
        out_item_nxt.epoch_count        = epoch_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_cnt_r  <= fjpm_pkg::BLK_CNT_RST;
      lppb_r     <= fjpm_pkg::LPPB_RST;
      lgp_r      <= fjpm_pkg::LGP_RST;
      head_r     <= '0;
      tail_r     <= '0;
      root_r     <= '0;
      root_def_r <= 1'b0;
      epoch_r    <= '0;
      bad_this_r <= '0;
      bad_last_r <= fjpm_pkg::BAD_LAST_RST;
      clr_addr_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          fjpm_pkg::CFG_BLOCK_COUNT: blk_cnt_r <= cfg_data;
          fjpm_pkg::CFG_LOG2_PPB:    lppb_r    <= cfg_data[3:0];
          fjpm_pkg::CFG_LOG2_GROUP:  lgp_r     <= cfg_data[3:0];
          default: ;
        endcase
      end
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      root_r     <= root_nxt;
      root_def_r <= root_def_nxt;
      epoch_r    <= epoch_nxt;
      bad_this_r <= bad_this_nxt;
      bad_last_r <= bad_last_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt;  bnum_r <= bnum_nxt;  status_r <= status_nxt;
    erq_r <= erq_nxt;  eblk_r <= eblk_nxt;  cprq_r <= cprq_nxt;  cpage_r <= cpage_nxt;
    old_r <= old_nxt;  blk_r <= blk_nxt;  cur_r <= cur_nxt;  last_r <= last_nxt;
    e_r <= e_nxt;  cnt_r <= cnt_nxt;
    total_r <= total_nxt;  mb_r <= mb_nxt;  hlt_r <= hlt_nxt;  hp_r <= hp_nxt;
    addc_r <= addc_nxt;  gz_r <= gz_nxt;  good_r <= good_nxt;  hc_r <= hc_nxt;
    pneg_r <= pneg_nxt;  pages_r <= pages_nxt;  cpsc_r <= cpsc_nxt;
    cneg_r <= cneg_nxt;  cps_r <= cps_nxt;  size_r <= size_nxt;  cap_r <= cap_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) bad_mem[mem_waddr] <= mem_wdata;
    rd_bad_r <= bad_mem[mem_raddr];
  end

  assign out_item = out_item_r;

endmodule

// ===== rtl/fjpm_ctrl.sv =====
// Controller state machine: sequences the datapath and runs the channel handshakes.
// Depends on fjpm_pkg for state, command and status types.
module fjpm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  fjpm_pkg::dp_stat_t stat,
  output fjpm_pkg::dp_op_t   op
);

  fjpm_pkg::state_t state_r, state_nxt;
  logic             pre_r, pre_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fjpm_pkg::S_CLEAR;
      pre_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pre_r       <= pre_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pre_nxt       = pre_r;
    out_valid_nxt = out_valid_r && !out_ready;
    op            = fjpm_pkg::DP_NONE;
    in_ready      = 1'b0;

    unique case (state_r)
      fjpm_pkg::S_CLEAR: begin
        op = fjpm_pkg::DP_CLR;
        if (stat.clr_done) state_nxt = fjpm_pkg::S_IDLE;
      end
      fjpm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op        = fjpm_pkg::DP_LOAD;
          state_nxt = fjpm_pkg::S_EXEC;
        end
      end
      fjpm_pkg::S_EXEC: begin
        state_nxt = fjpm_pkg::S_MET1;
        unique case (stat.action)
          fjpm_pkg::ACT_RESET:   op = fjpm_pkg::DP_INIT;
          fjpm_pkg::ACT_MARK:    op = fjpm_pkg::DP_MARK;
          fjpm_pkg::ACT_ENQUEUE: pre_nxt = 1'b1;
          fjpm_pkg::ACT_DEQUEUE: begin
            op = fjpm_pkg::DP_DEQ;
            if (stat.deq_scan) state_nxt = fjpm_pkg::S_TS_A;
          end
          fjpm_pkg::ACT_CLEAR:   op = fjpm_pkg::DP_CLEARJ;
          default: ;
        endcase
      end
      fjpm_pkg::S_MET1: begin
        op = fjpm_pkg::DP_MET1;
        state_nxt = fjpm_pkg::S_MET2;
      end
      fjpm_pkg::S_MET2: begin
        op = fjpm_pkg::DP_MET2;
        state_nxt = fjpm_pkg::S_MET3;
      end
      fjpm_pkg::S_MET3: begin
        op = fjpm_pkg::DP_MET3;
        state_nxt = fjpm_pkg::S_MET4;
      end
      fjpm_pkg::S_MET4: begin
        op = fjpm_pkg::DP_MET4;
        state_nxt = fjpm_pkg::S_MET5;
      end
      fjpm_pkg::S_MET5: begin
        op = fjpm_pkg::DP_MET5;
        pre_nxt = 1'b0;
        state_nxt = pre_r ? fjpm_pkg::S_ENQ_CHK : fjpm_pkg::S_FIN;
      end
      fjpm_pkg::S_ENQ_CHK: begin
        // a full journal changes nothing, so the metrics stand
        if (stat.full) begin
          op        = fjpm_pkg::DP_ENQ_FULL;
          state_nxt = fjpm_pkg::S_FIN;
        end else begin
          state_nxt = fjpm_pkg::S_ENQ_PROG;
        end
      end
      fjpm_pkg::S_ENQ_PROG: begin
        op = fjpm_pkg::DP_ENQ_PROG;
        state_nxt = stat.enq_scan ? fjpm_pkg::S_HS_A : fjpm_pkg::S_MET1;
      end
      fjpm_pkg::S_HS_A: begin
        op = fjpm_pkg::DP_HS_A;
        state_nxt = fjpm_pkg::S_HS_B;
      end
      fjpm_pkg::S_HS_B: begin
        op = fjpm_pkg::DP_HS_B;
        if (stat.at_tail || !stat.rd_bad || stat.cnt_last) begin
          state_nxt = fjpm_pkg::S_MET1;
        end else begin
          state_nxt = fjpm_pkg::S_HS_A;
        end
      end
      fjpm_pkg::S_TS_A: begin
        op = fjpm_pkg::DP_TS_A;
        state_nxt = stat.at_head ? fjpm_pkg::S_MET1 : fjpm_pkg::S_TS_B;
      end
      fjpm_pkg::S_TS_B: begin
        op = fjpm_pkg::DP_TS_B;
        if (!stat.rd_bad || stat.cnt_last) begin
          state_nxt = fjpm_pkg::S_MET1;
        end else begin
          state_nxt = fjpm_pkg::S_TS_A;
        end
      end
      fjpm_pkg::S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          op            = fjpm_pkg::DP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = fjpm_pkg::S_IDLE;
        end
      end
      default: state_nxt = fjpm_pkg::S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/flash_journal_pointer_manager_top.sv =====
// Top level of the flash journal pointer manager.
// Instantiates fjpm_ctrl and fjpm_datapath; uses fjpm_pkg, fjpm_in_if, fjpm_out_if.
//
// Usage:
//   in_ch carries one action transaction (action, block_number); out_ch returns
//   exactly one result transaction per action. cfg_we/cfg_index/cfg_data write
//   block_count (0), log2_pages_per_block (1) and log2_group_pages (2); write
//   them only while the block is idle.
//   Reset, mark bad, clear and unused codes go straight to the size and
//   capacity pipeline (steps MET1 to MET5); dequeue may first run a tail scan
//   that reads the bad-block map block by block and may stop at the head block;
//   enqueue runs the pipeline, then on a full journal goes straight to the result,
//   else programs, runs the head scan when a block is used up (up to 8 blocks)
//   and runs the pipeline again. The bad-block map has a single read port.
//   One action is in work at a time; the next is taken the cycle after the
//   result loads the output register, even while the receiver stalls it.
//   After reset the bad-block map is cleared one entry per cycle, so in_ch
//   is not ready until all 4096 entries are cleared; configuration writes are taken meanwhile.
//   A stalled result is held unchanged until out_ch.ready.
module flash_journal_pointer_manager_top (
  input  logic                           clk,
  input  logic                           rst_n,
  fjpm_in_if.sink                        in_ch,
  fjpm_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [fjpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fjpm_pkg::CFG_W-1:0]     cfg_data
);

  fjpm_pkg::dp_op_t    op;
  fjpm_pkg::dp_stat_t  stat;
  fjpm_pkg::out_item_t out_item;
  logic                in_ready, out_valid;

  fjpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .op        (op)
  );

  fjpm_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .op              (op),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_action       (in_ch.action),
    .in_block_number (in_ch.block_number),
    .stat            (stat),
    .out_item        (out_item)
  );

  assign in_ch.ready               = in_ready;
  assign out_ch.valid              = out_valid;
  assign out_ch.status             = out_item.status;
  assign out_ch.head_page          = out_item.head_page;
  assign out_ch.tail_page          = out_item.tail_page;
  assign out_ch.root_page          = out_item.root_page;
  assign out_ch.root_valid         = out_item.root_valid;
  assign out_ch.erase_request      = out_item.erase_request;
  assign out_ch.erase_block_number = out_item.erase_block_number;
  assign out_ch.checkpoint_request = out_item.checkpoint_request;
  assign out_ch.checkpoint_page    = out_item.checkpoint_page;
  assign out_ch.journal_size       = out_item.journal_size;
  assign out_ch.journal_capacity   = out_item.journal_capacity;
  assign out_ch.epoch_count        = out_item.epoch_count;

endmodule

// ===== rtl/fjpm_checker.sv =====
// Port-level checks of the journal pointer manager result channel.
// Bound to flash_journal_pointer_manager_top; depends on fjpm_pkg.
module fjpm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  status,
  input logic [fjpm_pkg::PAGE_W-1:0] root_page,
  input logic                        root_valid,
  input logic                        erase_request,
  input logic [fjpm_pkg::BLK_W-1:0]  erase_block_number,
  input logic                        checkpoint_request,
  input logic [fjpm_pkg::PAGE_W-1:0] checkpoint_page
);

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(root_page))
    else $error("stalled result changed");

  a_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !root_valid |-> root_page == '0)
    else $error("root page without valid root");

  a_req_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (erase_request || erase_block_number == '0) &&
                  (checkpoint_request || checkpoint_page == '0))
    else $error("request address without request");

  // a full journal programs nothing
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == fjpm_pkg::STS_FULL |-> !erase_request && !checkpoint_request)
    else $error("request on full journal");

endmodule

bind flash_journal_pointer_manager_top fjpm_checker u_fjpm_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .status             (out_ch.status),
  .root_page          (out_ch.root_page),
  .root_valid         (out_ch.root_valid),
  .erase_request      (out_ch.erase_request),
  .erase_block_number (out_ch.erase_block_number),
  .checkpoint_request (out_ch.checkpoint_request),
  .checkpoint_page    (out_ch.checkpoint_page)
);
